[hdl/svp_pkg.sv]
// ----------------------------------------------------------------------------
// svp_pkg
// Shared constants, payload types and control structs of the sample voice
// playback block.
// ----------------------------------------------------------------------------
package svp_pkg;

  localparam int VOICE_SLOTS  = 32;
  localparam int SAMPLE_WORDS = 65536;

  localparam int ADDR_W = $clog2(SAMPLE_WORDS);
  localparam int VIDX_W = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  // Width that holds base plus position without overflow and covers the address.
  localparam int EXT_W  = (ADDR_W > 18) ? ADDR_W : 18;
  localparam int CFG_W  = 6;
  localparam int POS_W  = 17;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_PLAY   = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_OFFSET = 3'd3;
  localparam logic [2:0] CMD_LOOP   = 3'd4;
  localparam logic [2:0] CMD_RENDER = 3'd5;

  localparam logic [1:0] FMT_S8  = 2'd1;
  localparam logic [1:0] FMT_S16 = 2'd2;

  localparam logic [CFG_W-1:0]  VOICE_COUNT_RST = 6'd32;
  localparam logic signed [9:0]  S8_GAIN         = 10'sd258;
  localparam logic signed [15:0] Q15_MIN         = 16'sh8000;

  typedef struct packed {
    logic [2:0]        command;
    logic [4:0]        voice;
    logic [1:0]        format;
    logic [15:0]       address;
    logic signed [15:0] sample_word;
    logic [16:0]       length;
    logic [16:0]       offset;
    logic              loop_enable;
    logic [16:0]       loop_start;
    logic [16:0]       loop_end;
  } svp_in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic              audible;
    logic [16:0]       read_position;
  } svp_out_t;

  typedef struct packed {
    logic             active;
    logic [1:0]       fmt;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] len;
    logic [15:0]      base;
    logic             loop_en;
    logic [POS_W-1:0] loop_beg;
    logic [POS_W-1:0] loop_last;
  } voice_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic render;
  } dp_status_t;

endpackage

[hdl/svp_ctrl.sv]
// ----------------------------------------------------------------------------
// svp_ctrl
// Sequencer of the sample voice playback block: takes one beat, runs it
// through the datapath and hands a render result to the output register.
// ----------------------------------------------------------------------------
module svp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  svp_pkg::dp_status_t status,
  output svp_pkg::dp_cmd_t    cmd
);
  import svp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_full_r;
  logic       out_full_nxt;
  logic       out_free;

  assign out_free    = !out_full_r || !out_stall;
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.execute = (state_r == S_EXEC);
  assign cmd.emit    = (state_r == S_EMIT) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = status.render ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The output register stays full until the far side takes the beat.
  assign out_full_nxt = cmd.emit || (out_full_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_full_r;

endmodule

[hdl/svp_datapath.sv]
// ----------------------------------------------------------------------------
// svp_datapath
// Item register, per-voice state, sample memory, sample conversion and the
// output register of the sample voice playback block.
// ----------------------------------------------------------------------------
module svp_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  svp_pkg::svp_in_t         in_data,
  input  logic                     cfg_wr_en,
  input  logic [svp_pkg::CFG_W-1:0] cfg_wr_data,
  input  svp_pkg::dp_cmd_t         cmd,
  output svp_pkg::dp_status_t      status,
  output svp_pkg::svp_out_t        out_data
);
  import svp_pkg::*;

  svp_in_t           item_r;
  voice_t            voice_r [VOICE_SLOTS];
  logic [CFG_W-1:0]  voice_count_r;
  logic [15:0]       mem [SAMPLE_WORDS];
  logic [15:0]       mem_q_r;
  logic              heard_r;
  logic [1:0]        fmt_r;
  logic [POS_W-1:0]  rpos_r;
  svp_out_t          out_r;

  logic [8:0]        voice_ext;
  logic [VIDX_W-1:0] vidx;
  logic              voice_ok;
  voice_t            cur;
  voice_t            vnew;
  logic              wr_voice;
  logic [POS_W-1:0]  p_eff;
  logic              in_len;
  logic              heard_nxt;
  logic [17:0]       off_sum;
  logic [EXT_W-1:0]  rd_sum;
  logic [EXT_W-1:0]  wr_ext;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic signed [7:0]  byte_s;
  logic signed [17:0] prod;
  logic signed [15:0] sample_q15;

  // Voice decode: indices at or above the voice count are ignored.
  assign voice_ext = {4'b0, item_r.voice};
  assign vidx      = voice_ext[VIDX_W-1:0];
  assign voice_ok  = (voice_ext < {3'b0, voice_count_r}) &&
                     (voice_ext < 9'(VOICE_SLOTS));
  assign status.render = (item_r.command == CMD_RENDER) && voice_ok;

  assign cur = voice_r[vidx];

  // A looping voice past its loop end restarts from the loop start.
  assign p_eff  = (cur.active && cur.loop_en && (cur.pos > cur.loop_last)) ?
                  cur.loop_beg : cur.pos;
  assign in_len = (p_eff < cur.len);
  assign heard_nxt = cur.active && in_len &&
                     ((cur.fmt == FMT_S8) || (cur.fmt == FMT_S16));
  assign off_sum = {1'b0, cur.pos} + {1'b0, item_r.offset};

  assign rd_sum  = EXT_W'(cur.base) + EXT_W'(p_eff);
  assign rd_addr = rd_sum[ADDR_W-1:0];
  assign wr_ext  = EXT_W'(item_r.address);
  assign wr_addr = wr_ext[ADDR_W-1:0];

  always_comb begin
    vnew = cur;
    case (item_r.command)
      CMD_PLAY: begin
        vnew.pos    = '0;
        vnew.fmt    = item_r.format;
        vnew.len    = item_r.length;
        vnew.base   = item_r.address;
        vnew.active = 1'b1;
      end
      CMD_STOP: begin
        vnew.pos    = '0;
        vnew.len    = '0;
        vnew.active = 1'b0;
      end
      CMD_OFFSET: begin
        if (off_sum >= {1'b0, cur.len}) vnew.pos = cur.len;
        else                            vnew.pos = off_sum[POS_W-1:0];
      end
      CMD_LOOP: begin
        vnew.loop_en   = item_r.loop_enable;
        vnew.loop_beg  = item_r.loop_start;
        vnew.loop_last = item_r.loop_end;
      end
      CMD_RENDER: begin
        if (cur.active) vnew.pos = in_len ? (p_eff + 17'd1) : p_eff;
      end
      default: vnew = cur;
    endcase
  end

  assign wr_voice = cmd.execute && voice_ok && (item_r.command != CMD_LOAD);

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICE_SLOTS; i++) voice_r[i] <= '0;
    end else if (wr_voice) begin
      voice_r[vidx] <= vnew;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_count_r <= VOICE_COUNT_RST;
    end else if (cfg_wr_en) begin
      voice_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && (item_r.command == CMD_LOAD)) mem[wr_addr] <= item_r.sample_word;
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      heard_r <= heard_nxt;
      fmt_r   <= cur.fmt;
      rpos_r  <= p_eff;
    end
  end

  // 8-bit samples scale by 258; only the most negative code saturates.
  assign byte_s = mem_q_r[7:0];
  assign prod   = byte_s * S8_GAIN;

  always_comb begin
    if (!heard_r) begin
      sample_q15 = '0;
    end else if (fmt_r == FMT_S8) begin
      sample_q15 = (prod < -18'sd32768) ? Q15_MIN : prod[15:0];
    end else begin
      sample_q15 = mem_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.sample_out    <= sample_q15;
      out_r.audible       <= heard_r;
      out_r.read_position <= rpos_r;
    end
  end

  assign out_data = out_r;

endmodule

[hdl/sample_voice_playback.sv]
// ----------------------------------------------------------------------------
// sample_voice_playback
// Multi-voice sample player: a sample memory with per-voice playback and loop
// state, driven by load, play, stop, offset, loop and render commands.
// ----------------------------------------------------------------------------
//   Port group  Direction  Handshake           Payload
//   in_         input      in_valid/in_stall   svp_in_t command beat
//   out_        output     out_valid/out_stall svp_out_t rendered sample
//   cfg_        input      cfg_wr_en           voice count
//
// A beat is captured into the item register and executed in the next cycle. A
// render reads the sample memory through its registered read port and loads
// the output register in the emit state. Synchronous reset clears all voice
// state and sets the voice count to 32; sample memory is undefined until
// loaded. A new beat is taken while a result still waits in the output
// register; a render stalls only if that register is still full when its own
// result is ready.
// ----------------------------------------------------------------------------
module sample_voice_playback (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  svp_pkg::svp_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output svp_pkg::svp_out_t         out_data,
  input  logic                      cfg_wr_en,
  input  logic [svp_pkg::CFG_W-1:0] cfg_wr_data
);
  import svp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  svp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  svp_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_data    (out_data)
  );

endmodule
